// File: rtl/core/tli_pkg.sv
// tli_pkg: shared types and constants for the two-line intersection block
// no dependencies

package tli_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned DiffW    = CoordW + 1;     // point differences
  localparam int unsigned ProdW    = 2 * DiffW;      // 17x17 products
  localparam int unsigned CrossW   = ProdW + 1;      // den, num
  localparam int unsigned TermW    = DiffW + CrossW; // dax*num
  localparam int unsigned SumW     = TermW + 1;      // ax0*den + dax*num
  localparam int unsigned DivNW    = SumW + 8;       // 200*|s| + |den|
  localparam int unsigned DivDW    = CrossW + 1;     // 2*|den|
  localparam int unsigned OutW     = 57;
  localparam int unsigned FrontLat = 7;
  localparam int unsigned DivLat   = DivNW;

  typedef enum logic [1:0] {
    RelPoint    = 2'd0,
    RelSame     = 2'd1,
    RelParallel = 2'd2
  } relation_e;

  typedef struct packed {
    relation_e          relation;
    logic               neg_x;
    logic               neg_y;
    logic [DivNW-1:0]   num_x;
    logic [DivNW-1:0]   num_y;
    logic [DivDW-1:0]   den;
  } prep_t;

  typedef struct packed {
    relation_e relation;
    logic      neg_x;
    logic      neg_y;
  } side_t;

endpackage

// File: rtl/core/tli_in_if.sv
// tli_in_if / tli_out_if: valid-ready channels for line pairs and results
// depends on tli_pkg

interface tli_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tli_pkg::CoordW-1:0]   ax0;
  logic signed [tli_pkg::CoordW-1:0]   ay0;
  logic signed [tli_pkg::CoordW-1:0]   ax1;
  logic signed [tli_pkg::CoordW-1:0]   ay1;
  logic signed [tli_pkg::CoordW-1:0]   bx0;
  logic signed [tli_pkg::CoordW-1:0]   by0;
  logic signed [tli_pkg::CoordW-1:0]   bx1;
  logic signed [tli_pkg::CoordW-1:0]   by1;

  modport source (output valid, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, input ready);
  modport sink   (input valid, ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, output ready);
endinterface

interface tli_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        relation;
  logic signed [tli_pkg::OutW-1:0]   cross_x_hundredths;
  logic signed [tli_pkg::OutW-1:0]   cross_y_hundredths;

  modport source (output valid, relation, cross_x_hundredths, cross_y_hundredths,
                  input ready);
  modport sink   (input valid, relation, cross_x_hundredths, cross_y_hundredths,
                  output ready);
endinterface

// File: rtl/core/tli_front.sv
// tli_front: cross products, numerators and divider operand preparation
// seven register stages; depends on tli_pkg

module tli_front (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [tli_pkg::CoordW-1:0] ax0_i,
  input  logic signed [tli_pkg::CoordW-1:0] ay0_i,
  input  logic signed [tli_pkg::CoordW-1:0] ax1_i,
  input  logic signed [tli_pkg::CoordW-1:0] ay1_i,
  input  logic signed [tli_pkg::CoordW-1:0] bx0_i,
  input  logic signed [tli_pkg::CoordW-1:0] by0_i,
  input  logic signed [tli_pkg::CoordW-1:0] bx1_i,
  input  logic signed [tli_pkg::CoordW-1:0] by1_i,
  output tli_pkg::prep_t                    prep_o
);
  localparam int unsigned DW = tli_pkg::DiffW;
  localparam int unsigned PW = tli_pkg::ProdW;
  localparam int unsigned XW = tli_pkg::CrossW;
  localparam int unsigned TW = tli_pkg::TermW;
  localparam int unsigned SW = tli_pkg::SumW;
  localparam int unsigned CW = tli_pkg::CoordW;

  // stage 1
  logic signed [DW-1:0] dax1_q, day1_q, dbx1_q, dby1_q, ox1_q, oy1_q;
  logic signed [CW-1:0] ax01_q, ay01_q;
  // stage 2
  logic signed [PW-1:0] p_den0_q, p_den1_q, p_num0_q, p_num1_q, p_on0_q, p_on1_q;
  logic signed [DW-1:0] dax2_q, day2_q;
  logic signed [CW-1:0] ax02_q, ay02_q;
  // stage 3
  logic signed [XW-1:0] den3_q, num3_q;
  logic                 on_a3_q;
  logic signed [DW-1:0] dax3_q, day3_q;
  logic signed [CW-1:0] ax03_q, ay03_q;
  // stage 4
  logic signed [TW-1:0] tx0_q, tx1_q, ty0_q, ty1_q;
  logic signed [XW-1:0] den4_q;
  logic                 on_a4_q, on_b4_q;
  // stage 5
  logic signed [SW-1:0] sx5_q, sy5_q;
  logic signed [XW-1:0] den5_q;
  logic                 on_a5_q, on_b5_q;
  // stage 6
  logic [SW-1:0]        ax6_q, ay6_q;
  logic [XW-1:0]        aden6_q;
  logic                 negx6_q, negy6_q;
  tli_pkg::relation_e   rel6_q;
  // stage 7
  tli_pkg::prep_t       prep_q;

  logic                 zero5;

  assign zero5 = (den5_q == '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dax1_q <= DW'(ax1_i) - DW'(ax0_i);
      day1_q <= DW'(ay1_i) - DW'(ay0_i);
      dbx1_q <= DW'(bx1_i) - DW'(bx0_i);
      dby1_q <= DW'(by1_i) - DW'(by0_i);
      ox1_q  <= DW'(bx0_i) - DW'(ax0_i);
      oy1_q  <= DW'(by0_i) - DW'(ay0_i);
      ax01_q <= ax0_i;
      ay01_q <= ay0_i;

      p_den0_q <= PW'(dax1_q) * PW'(dby1_q);
      p_den1_q <= PW'(day1_q) * PW'(dbx1_q);
      p_num0_q <= PW'(ox1_q) * PW'(dby1_q);
      p_num1_q <= PW'(oy1_q) * PW'(dbx1_q);
      p_on0_q  <= PW'(dax1_q) * PW'(oy1_q);
      p_on1_q  <= PW'(day1_q) * PW'(ox1_q);
      dax2_q   <= dax1_q;
      day2_q   <= day1_q;
      ax02_q   <= ax01_q;
      ay02_q   <= ay01_q;

      den3_q  <= XW'(p_den0_q) - XW'(p_den1_q);
      num3_q  <= XW'(p_num0_q) - XW'(p_num1_q);
      on_a3_q <= (p_on0_q == p_on1_q);
      dax3_q  <= dax2_q;
      day3_q  <= day2_q;
      ax03_q  <= ax02_q;
      ay03_q  <= ay02_q;

      // point a0 on b's line test is the negated numerator being zero
      tx0_q   <= TW'(ax03_q) * TW'(den3_q);
      tx1_q   <= TW'(dax3_q) * TW'(num3_q);
      ty0_q   <= TW'(ay03_q) * TW'(den3_q);
      ty1_q   <= TW'(day3_q) * TW'(num3_q);
      den4_q  <= den3_q;
      on_a4_q <= on_a3_q;
      on_b4_q <= (num3_q == '0);

      sx5_q   <= SW'(tx0_q) + SW'(tx1_q);
      sy5_q   <= SW'(ty0_q) + SW'(ty1_q);
      den5_q  <= den4_q;
      on_a5_q <= on_a4_q;
      on_b5_q <= on_b4_q;

      ax6_q   <= sx5_q[SW-1] ? SW'(-sx5_q) : SW'(sx5_q);
      ay6_q   <= sy5_q[SW-1] ? SW'(-sy5_q) : SW'(sy5_q);
      aden6_q <= den5_q[XW-1] ? XW'(-den5_q) : XW'(den5_q);
      negx6_q <= sx5_q[SW-1] ^ den5_q[XW-1];
      negy6_q <= sy5_q[SW-1] ^ den5_q[XW-1];
      if (!zero5) begin
        rel6_q <= tli_pkg::RelPoint;
      end else if (on_a5_q && on_b5_q) begin
        rel6_q <= tli_pkg::RelSame;
      end else begin
        rel6_q <= tli_pkg::RelParallel;
      end

      // dividend 2*100*|s| + |den|, divisor 2*|den|
      prep_q.relation <= rel6_q;
      prep_q.neg_x    <= negx6_q;
      prep_q.neg_y    <= negy6_q;
      prep_q.num_x    <= (tli_pkg::DivNW'(ax6_q) << 7) + (tli_pkg::DivNW'(ax6_q) << 6)
                       + (tli_pkg::DivNW'(ax6_q) << 3) + tli_pkg::DivNW'(aden6_q);
      prep_q.num_y    <= (tli_pkg::DivNW'(ay6_q) << 7) + (tli_pkg::DivNW'(ay6_q) << 6)
                       + (tli_pkg::DivNW'(ay6_q) << 3) + tli_pkg::DivNW'(aden6_q);
      prep_q.den      <= {aden6_q, 1'b0};
    end
  end

  assign prep_o = prep_q;

endmodule

// File: rtl/core/tli_div.sv
// tli_div: pipelined restoring unsigned divider, one quotient bit per stage
// depends on tli_pkg

module tli_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [tli_pkg::DivNW-1:0]  num_i,
  input  logic [tli_pkg::DivDW-1:0]  den_i,
  output logic [tli_pkg::DivNW-1:0]  quo_o
);
  localparam int unsigned NW = tli_pkg::DivNW;
  localparam int unsigned DW = tli_pkg::DivDW;

  // shift word: dividend bits leave at the top, quotient bits enter at the bottom
  logic [NW-1:0] sh_q  [NW];
  logic [DW-1:0] rem_q [NW];
  logic [DW-1:0] den_q [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [NW-1:0] sh_in;
    logic [DW-1:0] rem_in, den_in;
    logic [DW:0]   trial;
    logic          fits;

    if (i == 0) begin : g_first
      assign sh_in  = num_i;
      assign rem_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign sh_in  = sh_q[i-1];
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
    end

    assign trial = {rem_in, sh_in[NW-1]};
    assign fits  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= fits ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        sh_q[i]  <= {sh_in[NW-2:0], fits};
        den_q[i] <= den_in;
      end
    end
  end

  assign quo_o = sh_q[NW-1];

endmodule

// File: rtl/core/two_line_intersection.sv
// two_line_intersection: top level, classifies two lines and finds their crossing
// depends on tli_pkg, tli_in_if, tli_out_if, tli_front, tli_div
//
// usage: one line pair per transfer on in_i, one result per transfer on out_o
// - in_i carries two points per line; out_o carries the relation code and the
//   crossing point in hundredths, rounded half away from zero, saturated to
//   57 bits; both coordinates are zero unless the lines meet in one point
// - path: the input transfer edge loads the first of 7 front stages, then 61
//   divider stages and 1 output register follow; a stall holds every stage
// - throughput: one pair per cycle unless stalled; the 61-stage bit-per-stage
//   divider sets the depth, and each stage holds one quotient bit of both coordinates
// - stall: the whole pipeline holds while a result waits and the receiver is
//   not ready; in_i.ready then drops, nothing is lost or repeated
// - reset: clears the valid bits only, the pipeline comes up empty and ready

module two_line_intersection (
  input  logic      clk_i,
  input  logic      rst_ni,
  tli_in_if.sink    in_i,
  tli_out_if.source out_o
);
  localparam int unsigned Lat = tli_pkg::FrontLat + tli_pkg::DivLat;
  localparam int unsigned NW  = tli_pkg::DivNW;
  localparam int unsigned OW  = tli_pkg::OutW;

  logic                en;
  logic [Lat-1:0]      vld_q;
  logic                out_vld_q;
  tli_pkg::prep_t      prep;
  tli_pkg::side_t      side_q [tli_pkg::DivLat];
  logic [NW-1:0]       quo_x, quo_y;
  tli_pkg::side_t      side_last;
  logic [1:0]          rel_q;
  logic signed [OW-1:0] x_q, y_q;

  // global stall: advance when the output slot is empty or being taken
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Lat-2:0], in_i.valid};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  tli_front u_front (
    .clk_i  (clk_i),
    .en_i   (en),
    .ax0_i  (in_i.ax0),
    .ay0_i  (in_i.ay0),
    .ax1_i  (in_i.ax1),
    .ay1_i  (in_i.ay1),
    .bx0_i  (in_i.bx0),
    .by0_i  (in_i.by0),
    .bx1_i  (in_i.bx1),
    .by1_i  (in_i.by1),
    .prep_o (prep)
  );

  tli_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (prep.num_x),
    .den_i (prep.den),
    .quo_o (quo_x)
  );

  tli_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (prep.num_y),
    .den_i (prep.den),
    .quo_o (quo_y)
  );

  // relation and signs ride alongside the divider stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= '{relation: prep.relation, neg_x: prep.neg_x, neg_y: prep.neg_y};
      for (int i = 1; i < int'(tli_pkg::DivLat); i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign side_last = side_q[tli_pkg::DivLat-1];

  // saturate the magnitude, apply the sign, zero for non-point relations
  function automatic logic signed [OW-1:0] finish(input logic [NW-1:0] q, input logic neg);
    logic [NW-1:0] lim;
    logic [OW-1:0] mag;
    lim = {{(NW-OW+1){1'b0}}, {(OW-1){1'b1}}} + NW'(neg);
    mag = OW'(q);
    if (q > lim) begin
      finish = neg ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
    end else begin
      finish = neg ? OW'(-mag) : mag;
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      rel_q <= side_last.relation;
      if (side_last.relation == tli_pkg::RelPoint) begin
        x_q <= finish(quo_x, side_last.neg_x);
        y_q <= finish(quo_y, side_last.neg_y);
      end else begin
        x_q <= '0;
        y_q <= '0;
      end
    end
  end

  assign out_o.valid              = out_vld_q;
  assign out_o.relation           = rel_q;
  assign out_o.cross_x_hundredths = x_q;
  assign out_o.cross_y_hundredths = y_q;

  // no fourth relation code ever leaves the block
  a_rel_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.relation != 2'd3))
    else $error("relation code out of range");

  // coordinates are zero whenever the lines do not meet in one point
  a_zero_coords : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.relation != tli_pkg::RelPoint)) |->
      ((out_o.cross_x_hundredths == '0) && (out_o.cross_y_hundredths == '0)))
    else $error("nonzero coordinates without a single crossing point");

  // a held result blocks intake in the same cycle
  a_stall_blocks_intake : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |-> !in_i.ready)
    else $error("intake open while a result is stalled");

endmodule
